[rtl/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Shared constants, payload types, sequencer codes and divisor helpers for
// the Taylor-series sine/cosine block.
// ----------------------------------------------------------------------------
package sct_pkg;

  // series and output format
  localparam int MAX_TERMS = 15;
  localparam int FRAC_BITS = 24;
  localparam int WORK_FRAC = 48;
  localparam int OUT_SHIFT = WORK_FRAC - FRAC_BITS;

  // port field widths
  localparam int ANGLE_W = 16;
  localparam int COUNT_W = 4;
  localparam int OUT_W   = 32;

  // internal value widths, sized from the worst case over one full turn
  localparam int MAG_IN_W = ANGLE_W + 1;  // magnitude of the input angle
  localparam int DEG_W    = 9;            // reduced angle, 0..359
  localparam int X_W      = 51;           // radians, below 2*pi
  localparam int X2_W     = 54;           // x squared, below 40
  localparam int TERM_W   = 56;           // largest term stays below 128
  localparam int PROD_W   = 60;           // product before a division
  localparam int SUM_W    = 60;           // signed partial sums

  // shared multiplier
  localparam int LIMB_W  = 32;
  localparam int OPND_W  = 2 * LIMB_W;
  localparam int ACC_W   = 2 * OPND_W;
  localparam int MUL_PP  = 4;             // partial products per multiply
  localparam int MSTEP_W = 3;

  // iterative divider
  localparam int DIVISOR_W  = 10;
  localparam int RADIX_BITS = 4;
  localparam int DIV_STEPS  = PROD_W / RADIX_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // pi truncated to WORK_FRAC fractional bits
  localparam logic [49:0] PI_WORK = 50'h3243F6A8885A3;

  localparam logic [DIVISOR_W-1:0] FULL_TURN = DIVISOR_W'(360);
  localparam logic [DIVISOR_W-1:0] HALF_TURN = DIVISOR_W'(180);

  // 1.0 in the working format
  localparam logic [TERM_W-1:0] ONE_WORK = TERM_W'(64'd1 << WORK_FRAC);

  // payload of one transfer in each direction
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_deg;
    logic        [COUNT_W-1:0] term_count;
  } sct_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sine_value;
    logic signed [OUT_W-1:0] cosine_value;
    logic                    saturated;
  } sct_result_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV,
    ST_MUL,
    ST_MUL_WB,
    ST_CONV,
    ST_OUT
  } state_t;

  // operation currently on the shared units
  typedef enum logic [2:0] {
    OP_MOD,   // angle magnitude modulo 360
    OP_ANG,   // degrees times pi
    OP_RAD,   // divide by 180
    OP_SQR,   // x squared
    OP_SMUL,  // sine term times x squared
    OP_SDIV,  // sine term divided by 2k(2k+1)
    OP_CMUL,  // cosine term times x squared
    OP_CDIV   // cosine term divided by (2k-1)2k
  } op_t;

  // sine divisor 2k(2k+1)
  function automatic logic [DIVISOR_W-1:0] sin_divisor(input logic [COUNT_W-1:0] k);
    logic [DIVISOR_W-1:0] twok;
    twok = DIVISOR_W'({k, 1'b0});
    return DIVISOR_W'(twok * (twok + DIVISOR_W'(1)));
  endfunction

  // cosine divisor (2k-1)2k
  function automatic logic [DIVISOR_W-1:0] cos_divisor(input logic [COUNT_W-1:0] k);
    logic [DIVISOR_W-1:0] twok;
    twok = DIVISOR_W'({k, 1'b0});
    return DIVISOR_W'(twok * (twok - DIVISOR_W'(1)));
  endfunction

endpackage

[rtl/sct_mul32.sv]
// ----------------------------------------------------------------------------
// sct_mul32
// Shared 32x32 unsigned multiplier with a registered product; wide products
// are built from its partial products by the sequencer.
// ----------------------------------------------------------------------------
module sct_mul32 (
  input  logic                           clk,
  input  logic [sct_pkg::LIMB_W-1:0]     a,
  input  logic [sct_pkg::LIMB_W-1:0]     b,
  output logic [2*sct_pkg::LIMB_W-1:0]   p
);

  // one partial product per cycle
  always_ff @(posedge clk) begin
    p <= {{sct_pkg::LIMB_W{1'b0}}, a} * {{sct_pkg::LIMB_W{1'b0}}, b};
  end

endmodule

[rtl/sct_div.sv]
// ----------------------------------------------------------------------------
// sct_div
// Iterative restoring divider, four quotient bits per cycle; gives the
// truncated quotient and the remainder of a wide dividend by a short divisor.
// ----------------------------------------------------------------------------
module sct_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sct_pkg::PROD_W-1:0]        dividend,
  input  logic [sct_pkg::DIVISOR_W-1:0]     divisor,
  output logic [sct_pkg::PROD_W-1:0]        quotient,
  output logic [sct_pkg::DIVISOR_W-1:0]     remainder,
  output logic                              done
);

  logic [sct_pkg::PROD_W-1:0]     quot;
  logic [sct_pkg::DIVISOR_W-1:0]  rem;
  logic [sct_pkg::DIVISOR_W-1:0]  dvs;
  logic [sct_pkg::DIV_CNT_W-1:0]  cnt;
  logic [sct_pkg::DIVISOR_W:0]    part;
  logic [sct_pkg::RADIX_BITS-1:0] bits;

  // four shift-subtract steps on the narrow partial remainder
  always_comb begin
    part = {1'b0, rem};
    bits = '0;
    for (int i = 0; i < sct_pkg::RADIX_BITS; i++) begin
      part = {part[sct_pkg::DIVISOR_W-1:0], quot[sct_pkg::PROD_W-1-i]};
      if (part >= {1'b0, dvs}) begin
        part = part - {1'b0, dvs};
        bits[sct_pkg::RADIX_BITS-1-i] = 1'b1;
      end
    end
  end

  // step counter and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == sct_pkg::DIV_CNT_W'(1));
      if (start) begin
        cnt <= sct_pkg::DIV_CNT_W'(sct_pkg::DIV_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - sct_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (cnt != '0) begin
      quot <= {quot[sct_pkg::PROD_W-sct_pkg::RADIX_BITS-1:0], bits};
      rem  <= part[sct_pkg::DIVISOR_W-1:0];
    end
  end

  assign quotient  = quot;
  assign remainder = rem;

endmodule

[rtl/sct_sat.sv]
// ----------------------------------------------------------------------------
// sct_sat
// Converts a signed working-format sum to the 32-bit output format:
// optional sign flip, magnitude truncation, clamping with a flag.
// ----------------------------------------------------------------------------
module sct_sat (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [sct_pkg::SUM_W-1:0]  sum,
  input  logic                              flip,
  output logic signed [sct_pkg::OUT_W-1:0]  value,
  output logic                              clamped
);

  localparam int MAG_W = sct_pkg::SUM_W - sct_pkg::OUT_SHIFT;
  localparam logic [MAG_W-1:0] POS_MAX = MAG_W'(33'h0_7FFF_FFFF);
  localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(33'h0_8000_0000);

  logic [sct_pkg::SUM_W-1:0] abs_sum;
  logic [MAG_W-1:0]          mag;
  logic                      neg;
  logic [sct_pkg::OUT_W-1:0] lim;

  // magnitude of the sum
  assign abs_sum = sum[sct_pkg::SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);

  // register truncated magnitude and final sign
  always_ff @(posedge clk) begin
    if (load) begin
      mag <= abs_sum[sct_pkg::SUM_W-1:sct_pkg::OUT_SHIFT];
      neg <= sum[sct_pkg::SUM_W-1] ^ flip;
    end
  end

  // clamp and restore the sign
  always_comb begin
    clamped = neg ? (mag > NEG_MAX) : (mag > POS_MAX);
    if (clamped) begin
      lim = neg ? sct_pkg::OUT_W'(NEG_MAX) : sct_pkg::OUT_W'(POS_MAX);
    end else begin
      lim = mag[sct_pkg::OUT_W-1:0];
    end
    value = $signed(neg ? sct_pkg::OUT_W'(-lim) : lim);
  end

endmodule

[rtl/sine_cosine_taylor_series.sv]
// ----------------------------------------------------------------------------
// sine_cosine_taylor_series
// Truncated Taylor-series sine and cosine of an integer angle in degrees.
// An item is taken when start is high and busy is low; busy then stays high
// while the series is summed up to term n, n being the clamped term count.
// The time goes to the shared units: each division is done by the
// four-bit-per-cycle divider, each wide multiply takes four passes through
// the one 32x32 multiplier, and every series term needs one of each for
// sine and for cosine. The result appears for exactly one cycle with done
// high, in the same cycle as busy drops; there is no way to hold it, so the
// receiver must capture it in that cycle. Outputs are signed Q7.24; saturated
// marks a clamp on either of them.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_series (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sct_pkg::sct_item_t   item,
  output logic                 done,
  output sct_pkg::sct_result_t result
);

  sct_pkg::state_t state, state_next;
  sct_pkg::op_t    op, op_next;

  logic [sct_pkg::MSTEP_W-1:0]    mstep, mstep_next;
  logic                           pp_valid, pp_valid_next;
  logic [1:0]                     pp_pos, pp_pos_next;
  logic [sct_pkg::ACC_W-1:0]      acc, acc_next;

  logic                           neg, neg_next;
  logic [sct_pkg::MAG_IN_W-1:0]   mag_in, mag_in_next;
  logic [sct_pkg::DEG_W-1:0]      deg, deg_next;
  logic [sct_pkg::COUNT_W-1:0]    n, n_next;
  logic [sct_pkg::COUNT_W-1:0]    k, k_next;
  logic [sct_pkg::X_W-1:0]        x, x_next;
  logic [sct_pkg::X2_W-1:0]       x2, x2_next;
  logic [sct_pkg::TERM_W-1:0]     ts, ts_next;
  logic [sct_pkg::TERM_W-1:0]     tc, tc_next;
  logic [sct_pkg::PROD_W-1:0]     prod, prod_next;
  logic signed [sct_pkg::SUM_W-1:0] ssum, ssum_next;
  logic signed [sct_pkg::SUM_W-1:0] csum, csum_next;
  sct_pkg::sct_result_t           result_next;

  logic [sct_pkg::MAG_IN_W-1:0]   raw_ext;
  logic [sct_pkg::MAG_IN_W-1:0]   in_mag;
  logic [sct_pkg::OPND_W-1:0]     opa, opb;
  logic [sct_pkg::LIMB_W-1:0]     a_limb, b_limb;
  logic [2*sct_pkg::LIMB_W-1:0]   pp;
  logic                           div_start;
  logic [sct_pkg::PROD_W-1:0]     dividend;
  logic [sct_pkg::DIVISOR_W-1:0]  divisor;
  logic [sct_pkg::PROD_W-1:0]     div_quot;
  logic [sct_pkg::DIVISOR_W-1:0]  div_rem;
  logic                           div_done;
  logic signed [sct_pkg::SUM_W-1:0] div_term;
  logic                           sat_load;
  logic signed [sct_pkg::OUT_W-1:0] sin_val, cos_val;
  logic                           sin_clamp, cos_clamp;

  // shared units
  sct_mul32 u_mul (
    .clk (clk),
    .a   (a_limb),
    .b   (b_limb),
    .p   (pp)
  );

  sct_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (div_quot),
    .remainder (div_rem),
    .done      (div_done)
  );

  sct_sat u_sat_sin (
    .clk     (clk),
    .load    (sat_load),
    .sum     (ssum),
    .flip    (neg),
    .value   (sin_val),
    .clamped (sin_clamp)
  );

  sct_sat u_sat_cos (
    .clk     (clk),
    .load    (sat_load),
    .sum     (csum),
    .flip    (1'b0),
    .value   (cos_val),
    .clamped (cos_clamp)
  );

  // magnitude of the incoming angle
  assign raw_ext = {1'b0, item.angle_deg};
  assign in_mag  = item.angle_deg[sct_pkg::ANGLE_W-1]
                 ? (sct_pkg::MAG_IN_W'(1) << sct_pkg::ANGLE_W) - raw_ext
                 : raw_ext;

  assign busy = (state != sct_pkg::ST_IDLE);

  // operand selection for the shared units
  always_comb begin
    opa      = '0;
    opb      = '0;
    dividend = '0;
    divisor  = '0;
    case (op)
      sct_pkg::OP_MOD: begin
        dividend = sct_pkg::PROD_W'(mag_in);
        divisor  = sct_pkg::FULL_TURN;
      end
      sct_pkg::OP_ANG: begin
        opa = sct_pkg::OPND_W'(deg);
        opb = sct_pkg::OPND_W'(sct_pkg::PI_WORK);
      end
      sct_pkg::OP_RAD: begin
        dividend = prod;
        divisor  = sct_pkg::HALF_TURN;
      end
      sct_pkg::OP_SQR: begin
        opa = sct_pkg::OPND_W'(x);
        opb = sct_pkg::OPND_W'(x);
      end
      sct_pkg::OP_SMUL: begin
        opa = sct_pkg::OPND_W'(ts);
        opb = sct_pkg::OPND_W'(x2);
      end
      sct_pkg::OP_SDIV: begin
        dividend = prod;
        divisor  = sct_pkg::sin_divisor(k);
      end
      sct_pkg::OP_CMUL: begin
        opa = sct_pkg::OPND_W'(tc);
        opb = sct_pkg::OPND_W'(x2);
      end
      sct_pkg::OP_CDIV: begin
        dividend = prod;
        divisor  = sct_pkg::cos_divisor(k);
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  // limb pair for this multiply pass
  assign a_limb = mstep[1] ? opa[2*sct_pkg::LIMB_W-1:sct_pkg::LIMB_W] : opa[sct_pkg::LIMB_W-1:0];
  assign b_limb = mstep[0] ? opb[2*sct_pkg::LIMB_W-1:sct_pkg::LIMB_W] : opb[sct_pkg::LIMB_W-1:0];

  // partial-product bookkeeping and accumulation
  always_comb begin
    pp_valid_next = (state == sct_pkg::ST_MUL) && (mstep != sct_pkg::MSTEP_W'(sct_pkg::MUL_PP));
    pp_pos_next   = {1'b0, mstep[1]} + {1'b0, mstep[0]};
    if (state == sct_pkg::ST_MUL) begin
      if (pp_valid) begin
        acc_next = acc + (sct_pkg::ACC_W'(pp) << (pp_pos * sct_pkg::LIMB_W));
      end else begin
        acc_next = acc;
      end
    end else begin
      acc_next = '0;
    end
  end

  // new term from the divider, as a signed sum operand
  assign div_term = $signed(sct_pkg::SUM_W'(div_quot[sct_pkg::TERM_W-1:0]));

  // sequencer
  always_comb begin
    state_next  = state;
    op_next     = op;
    mstep_next  = mstep;
    neg_next    = neg;
    mag_in_next = mag_in;
    deg_next    = deg;
    n_next      = n;
    k_next      = k;
    x_next      = x;
    x2_next     = x2;
    ts_next     = ts;
    tc_next     = tc;
    prod_next   = prod;
    ssum_next   = ssum;
    csum_next   = csum;
    result_next = result;
    div_start   = 1'b0;
    sat_load    = 1'b0;

    case (state)
      sct_pkg::ST_IDLE: begin
        if (start) begin
          neg_next    = item.angle_deg[sct_pkg::ANGLE_W-1];
          mag_in_next = in_mag;
          n_next      = (item.term_count > sct_pkg::COUNT_W'(sct_pkg::MAX_TERMS))
                      ? sct_pkg::COUNT_W'(sct_pkg::MAX_TERMS) : item.term_count;
          op_next     = sct_pkg::OP_MOD;
          state_next  = sct_pkg::ST_DIV_START;
        end
      end

      sct_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = sct_pkg::ST_DIV;
      end

      // divider writeback
      sct_pkg::ST_DIV: begin
        if (div_done) begin
          case (op)
            sct_pkg::OP_MOD: begin
              deg_next   = div_rem[sct_pkg::DEG_W-1:0];
              op_next    = sct_pkg::OP_ANG;
              state_next = sct_pkg::ST_MUL;
            end
            sct_pkg::OP_RAD: begin
              x_next     = div_quot[sct_pkg::X_W-1:0];
              op_next    = sct_pkg::OP_SQR;
              state_next = sct_pkg::ST_MUL;
            end
            sct_pkg::OP_SDIV: begin
              ts_next    = div_quot[sct_pkg::TERM_W-1:0];
              ssum_next  = k[0] ? ssum - div_term : ssum + div_term;
              op_next    = sct_pkg::OP_CMUL;
              state_next = sct_pkg::ST_MUL;
            end
            sct_pkg::OP_CDIV: begin
              tc_next   = div_quot[sct_pkg::TERM_W-1:0];
              csum_next = k[0] ? csum - div_term : csum + div_term;
              if (k == n) begin
                state_next = sct_pkg::ST_CONV;
              end else begin
                k_next     = k + sct_pkg::COUNT_W'(1);
                op_next    = sct_pkg::OP_SMUL;
                state_next = sct_pkg::ST_MUL;
              end
            end
            default: begin
              state_next = sct_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // four passes through the multiplier, then one to drain
      sct_pkg::ST_MUL: begin
        if (mstep == sct_pkg::MSTEP_W'(sct_pkg::MUL_PP)) begin
          mstep_next = '0;
          state_next = sct_pkg::ST_MUL_WB;
        end else begin
          mstep_next = mstep + sct_pkg::MSTEP_W'(1);
        end
      end

      // multiplier writeback
      sct_pkg::ST_MUL_WB: begin
        case (op)
          sct_pkg::OP_ANG: begin
            prod_next  = acc[sct_pkg::PROD_W-1:0];
            op_next    = sct_pkg::OP_RAD;
            state_next = sct_pkg::ST_DIV_START;
          end
          sct_pkg::OP_SQR: begin
            x2_next   = acc[sct_pkg::WORK_FRAC +: sct_pkg::X2_W];
            ts_next   = sct_pkg::TERM_W'(x);
            tc_next   = sct_pkg::ONE_WORK;
            ssum_next = $signed(sct_pkg::SUM_W'(x));
            csum_next = $signed(sct_pkg::SUM_W'(sct_pkg::ONE_WORK));
            k_next    = sct_pkg::COUNT_W'(1);
            if (n == '0) begin
              state_next = sct_pkg::ST_CONV;
            end else begin
              op_next    = sct_pkg::OP_SMUL;
              state_next = sct_pkg::ST_MUL;
            end
          end
          sct_pkg::OP_SMUL: begin
            prod_next  = acc[sct_pkg::WORK_FRAC +: sct_pkg::PROD_W];
            op_next    = sct_pkg::OP_SDIV;
            state_next = sct_pkg::ST_DIV_START;
          end
          sct_pkg::OP_CMUL: begin
            prod_next  = acc[sct_pkg::WORK_FRAC +: sct_pkg::PROD_W];
            op_next    = sct_pkg::OP_CDIV;
            state_next = sct_pkg::ST_DIV_START;
          end
          default: begin
            state_next = sct_pkg::ST_IDLE;
          end
        endcase
      end

      sct_pkg::ST_CONV: begin
        sat_load   = 1'b1;
        state_next = sct_pkg::ST_OUT;
      end

      sct_pkg::ST_OUT: begin
        result_next.sine_value   = sin_val;
        result_next.cosine_value = cos_val;
        result_next.saturated    = sin_clamp | cos_clamp;
        state_next               = sct_pkg::ST_IDLE;
      end

      default: begin
        state_next = sct_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sct_pkg::ST_IDLE;
      op       <= sct_pkg::OP_MOD;
      mstep    <= '0;
      pp_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      op       <= op_next;
      mstep    <= mstep_next;
      pp_valid <= pp_valid_next;
      done     <= (state == sct_pkg::ST_OUT);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pp_pos <= pp_pos_next;
    acc    <= acc_next;
    neg    <= neg_next;
    mag_in <= mag_in_next;
    deg    <= deg_next;
    n      <= n_next;
    k      <= k_next;
    x      <= x_next;
    x2     <= x2_next;
    ts     <= ts_next;
    tc     <= tc_next;
    prod   <= prod_next;
    ssum   <= ssum_next;
    csum   <= csum_next;
    result <= result_next;
  end

endmodule
